// ===== hdl/dqi_pkg.sv =====
// shared types and codes for the double-ended queue with index read
package dqi_pkg;

    localparam logic [2:0] ACT_PUSH_FRONT = 3'd0;
    localparam logic [2:0] ACT_PUSH_BACK  = 3'd1;
    localparam logic [2:0] ACT_POP_FRONT  = 3'd2;
    localparam logic [2:0] ACT_POP_BACK   = 3'd3;
    localparam logic [2:0] ACT_READ       = 3'd4;

    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_OVERFLOW  = 2'd1;
    localparam logic [1:0] ST_UNDERFLOW = 2'd2;
    localparam logic [1:0] ST_RANGE     = 2'd3;

    typedef struct packed {
        logic [2:0]  action;
        logic [31:0] point_in;
        logic [5:0]  position;
    } request_t;

    typedef struct packed {
        logic [31:0] point_out;
        logic [6:0]  count_now;
        logic        is_empty;
        logic [1:0]  status;
    } result_t;

    // result fields that are registered alongside the memory read
    typedef struct packed {
        logic       valid;
        logic       has_data;
        logic [6:0] count_now;
        logic       is_empty;
        logic [1:0] status;
    } pend_t;

endpackage

// ===== hdl/dqi_ram.sv =====
// generic single-port-write, single-port-read ram with registered read
module dqi_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// ===== hdl/dqi_ctrl.sv =====
// ring pointer and count keeping, memory addressing and status for each request
module dqi_ctrl
    import dqi_pkg::*;
#(
    parameter int DEPTH       = 64,
    parameter int POINT_WIDTH = 32
) (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     start,
    input  request_t                 req,
    output logic                     mem_we,
    output logic [$clog2(DEPTH)-1:0] mem_waddr,
    output logic [POINT_WIDTH-1:0]   mem_wdata,
    output logic [$clog2(DEPTH)-1:0] mem_raddr,
    output pend_t                    pend
);

    localparam int PW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);
    localparam int XW = (POINT_WIDTH > 32) ? POINT_WIDTH : 32;
    localparam int QW = (CW > 6) ? CW : 6;
    localparam logic [PW-1:0] LAST = PW'(DEPTH - 1);
    localparam logic [CW-1:0] FULL = CW'(DEPTH);

    logic [PW-1:0] front_reg, front_next;
    logic [CW-1:0] count_reg, count_next;
    pend_t         pend_reg, pend_next;

    logic          full, empty, pos_bad;
    logic [1:0]    status;
    logic          has_data;
    logic [XW-1:0] point_ext;

    // modular add of two in-range ring indexes
    function automatic logic [PW-1:0] ring_add(input logic [PW-1:0] a, input logic [PW-1:0] b);
        logic [PW:0] s;
        s = {1'b0, a} + {1'b0, b};
        if (s >= (PW + 1)'(DEPTH))
        begin
            s = s - (PW + 1)'(DEPTH);
        end
        return s[PW-1:0];
    endfunction

    assign full      = (count_reg == FULL);
    assign empty     = (count_reg == '0);
    assign pos_bad   = (QW'(req.position) >= QW'(count_reg));
    assign point_ext = XW'(req.point_in);
    assign mem_wdata = point_ext[POINT_WIDTH-1:0];

    always_comb
    begin
        front_next = front_reg;
        count_next = count_reg;
        mem_we     = 1'b0;
        mem_waddr  = front_reg;
        mem_raddr  = front_reg;
        status     = ST_OK;
        has_data   = 1'b0;
        case (req.action)
            ACT_PUSH_FRONT:
            begin
                if (full)
                begin
                    status = ST_OVERFLOW;
                end
                else
                begin
                    front_next = (front_reg == '0) ? LAST : front_reg - 1'b1;
                    mem_we     = 1'b1;
                    mem_waddr  = front_next;
                    count_next = count_reg + 1'b1;
                end
            end
            ACT_PUSH_BACK:
            begin
                if (full)
                begin
                    status = ST_OVERFLOW;
                end
                else
                begin
                    mem_we     = 1'b1;
                    mem_waddr  = ring_add(front_reg, PW'(count_reg));
                    count_next = count_reg + 1'b1;
                end
            end
            ACT_POP_FRONT:
            begin
                if (empty)
                begin
                    status = ST_UNDERFLOW;
                end
                else
                begin
                    has_data   = 1'b1;
                    mem_raddr  = front_reg;
                    front_next = (front_reg == LAST) ? '0 : front_reg + 1'b1;
                    count_next = count_reg - 1'b1;
                end
            end
            ACT_POP_BACK:
            begin
                if (empty)
                begin
                    status = ST_UNDERFLOW;
                end
                else
                begin
                    has_data   = 1'b1;
                    mem_raddr  = ring_add(front_reg, PW'(count_reg - 1'b1));
                    count_next = count_reg - 1'b1;
                end
            end
            ACT_READ:
            begin
                if (pos_bad)
                begin
                    status = ST_RANGE;
                end
                else
                begin
                    has_data  = 1'b1;
                    mem_raddr = ring_add(front_reg, PW'(req.position));
                end
            end
            default:
            begin
                status = ST_OK;
            end
        endcase
        if (!start)
        begin
            mem_we = 1'b0;
        end
        pend_next.valid     = start;
        pend_next.has_data  = has_data;
        pend_next.count_now = 7'(count_next);
        pend_next.is_empty  = (count_next == '0);
        pend_next.status    = status;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            front_reg <= '0;
            count_reg <= '0;
            pend_reg  <= '0;
        end
        else
        begin
            if (start)
            begin
                front_reg <= front_next;
                count_reg <= count_next;
            end
            pend_reg <= pend_next;
        end
    end

    assign pend = pend_reg;

endmodule

// ===== hdl/double_ended_queue_with_index_read.sv =====
// result strobe (done) comes in the cycle after the request is taken
// throughput: one request per cycle; busy is never raised, since every action
// needs at most one memory write or one registered memory read and a push is visible
// to the next cycle's read
// the receiver cannot stall: each result shows for exactly one cycle with done
// reset clears the front pointer and the entry count; stored words stay undefined
module double_ended_queue_with_index_read
    import dqi_pkg::*;
#(
    parameter int DEPTH       = 64,
    parameter int POINT_WIDTH = 32
) (
    input  logic     clk,
    input  logic     rst_n,
    input  logic     start,
    output logic     busy,
    input  request_t request,
    output logic     done,
    output result_t  result
);

    localparam int AW = $clog2(DEPTH);
    localparam int XW = (POINT_WIDTH > 32) ? POINT_WIDTH : 32;

    logic                   mem_we;
    logic [AW-1:0]          mem_waddr;
    logic [POINT_WIDTH-1:0] mem_wdata;
    logic [AW-1:0]          mem_raddr;
    logic [POINT_WIDTH-1:0] mem_rdata;
    logic [XW-1:0]          rd_ext;
    pend_t                  pend;

    assign busy = 1'b0;

    dqi_ctrl #(
        .DEPTH       (DEPTH),
        .POINT_WIDTH (POINT_WIDTH)
    ) u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .req       (request),
        .mem_we    (mem_we),
        .mem_waddr (mem_waddr),
        .mem_wdata (mem_wdata),
        .mem_raddr (mem_raddr),
        .pend      (pend)
    );

    dqi_ram #(
        .WIDTH (POINT_WIDTH),
        .DEPTH (DEPTH)
    ) u_store (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    assign rd_ext = XW'(mem_rdata);

    always_comb
    begin
        done             = pend.valid;
        result.point_out = pend.has_data ? rd_ext[31:0] : '0;
        result.count_now = pend.count_now;
        result.is_empty  = pend.is_empty;
        result.status    = pend.status;
    end

endmodule
